// ===== sv/bist_pkg.sv =====
`default_nettype none

package bist_pkg;

    // Default table depth and field widths.
    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int REQ_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 5;
    localparam int CAP_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REWIND    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_NEXT = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL          = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ_PAST_END = 2'd3;

    typedef enum logic [1:0] {
        RD_SEL_IDX,
        RD_SEL_IDX_NEXT,
        RD_SEL_CURSOR
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_ADDR,
        S_SCAN_CMP,
        S_SCAN_DONE,
        S_SHIFT_ADDR,
        S_SHIFT_WR,
        S_READ_ADDR,
        S_READ_DATA,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                load;
        logic                scan_hit;
        logic                idx_inc;
        logic                append;
        logic                shift_wr;
        logic                dec_count;
        logic                rewind;
        logic                read_cap;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        rd_sel_t             rd_sel;
        logic                publish;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             scan_end;
        logic             match;
        logic             hit;
        logic             shift_end;
        logic             can_append;
        logic             cursor_ok;
        logic             out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/bist_req_if.sv =====
`default_nettype none

interface bist_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

// ===== sv/bist_rsp_if.sv =====
`default_nettype none

interface bist_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic               more_to_read;

    modport source (
        output valid, output status, output found, output read_value,
        output entry_count, output more_to_read, input ready
    );
    modport sink (
        input valid, input status, input found, input read_value,
        input entry_count, input more_to_read, output ready
    );
endinterface

`default_nettype wire

// ===== sv/bist_ram.sv =====
`default_nettype none

module bist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/bist_ctrl.sv =====
`default_nettype none

module bist_ctrl
    import bist_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.req_type)
                    REQ_QUERY, REQ_INSERT, REQ_REMOVE: state_next = S_SCAN_ADDR;
                    REQ_READ_NEXT:
                    begin
                        state_next = stat.cursor_ok ? S_READ_ADDR : S_FINISH;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_SCAN_ADDR:
            begin
                state_next = stat.scan_end ? S_SCAN_DONE : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = stat.match ? S_SCAN_DONE : S_SCAN_ADDR;
            end
            S_SCAN_DONE:
            begin
                if (stat.req_type == REQ_REMOVE && stat.hit)
                begin
                    state_next = S_SHIFT_ADDR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_ADDR:
            begin
                state_next = stat.shift_end ? S_FINISH : S_SHIFT_WR;
            end
            S_SHIFT_WR:  state_next = S_SHIFT_ADDR;
            S_READ_ADDR: state_next = S_READ_DATA;
            S_READ_DATA: state_next = S_FINISH;
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        cmd.rd_sel = RD_SEL_IDX;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DISPATCH:
            begin
                case (stat.req_type)
                    REQ_REWIND: cmd.rewind = 1'b1;
                    REQ_READ_NEXT:
                    begin
                        if (!stat.cursor_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_READ_PAST_END;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN_ADDR: cmd.rd_sel = RD_SEL_IDX;
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    cmd.scan_hit = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN_DONE:
            begin
                case (stat.req_type)
                    REQ_INSERT:
                    begin
                        if (stat.can_append)
                        begin
                            cmd.append = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (!stat.hit)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_ABSENT;
                        end
                    end
                    default: ;
                endcase
            end
            S_SHIFT_ADDR:
            begin
                cmd.rd_sel = RD_SEL_IDX_NEXT;
                if (stat.shift_end)
                begin
                    cmd.dec_count = 1'b1;
                end
            end
            S_SHIFT_WR:  cmd.shift_wr = 1'b1;
            S_READ_ADDR: cmd.rd_sel = RD_SEL_CURSOR;
            S_READ_DATA: cmd.read_cap = 1'b1;
            S_FINISH:    cmd.publish = stat.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bist_dp.sv =====
`default_nettype none

module bist_dp
    import bist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [REQ_W-1:0]    in_req_type,
    input  wire logic [VALUE_W-1:0]  in_value,
    input  wire logic                cfg_we,
    input  wire logic [CAP_W-1:0]    cfg_wdata,
    input  wire dp_cmd_t             cmd,
    output dp_stat_t                 stat,
    bist_rsp_if.source               rsp_ch
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int XW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    // Control state.
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    cursor_reg, cursor_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             out_valid_reg, out_valid_next;

    // Per-request working registers.
    logic [REQ_W-1:0]    req_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                hit_reg, hit_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  rdv_reg, rdv_next;

    // Result registers.
    logic [STATUS_W-1:0]    o_status_reg;
    logic                   o_found_reg;
    logic [VALUE_W-1:0]     o_value_reg;
    logic [COUNT_OUT_W-1:0] o_count_reg;
    logic                   o_more_reg;

    logic [AW-1:0]      ram_raddr;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_we;
    logic [VALUE_W-1:0] ram_rdata;

    logic [CW-1:0] idx_plus;
    logic [LW-1:0] limit;
    logic [XW-1:0] count_wide;

    assign idx_plus   = idx_reg + CW'(1);
    assign limit      = (LW'(cap_reg) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_reg);
    assign count_wide = XW'(count_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SEL_IDX_NEXT: ram_raddr = idx_plus[AW-1:0];
            RD_SEL_CURSOR:   ram_raddr = cursor_reg[AW-1:0];
            default:         ram_raddr = idx_reg[AW-1:0];
        endcase
    end

    assign ram_we    = cmd.append | cmd.shift_wr;
    assign ram_waddr = cmd.append ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign ram_wdata = cmd.append ? val_reg : ram_rdata;

    bist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.req_type   = req_reg;
        stat.scan_end   = (idx_reg >= count_reg);
        stat.match      = (ram_rdata == val_reg);
        stat.hit        = hit_reg;
        stat.shift_end  = (idx_plus >= count_reg);
        stat.can_append = (LW'(count_reg) < limit);
        stat.cursor_ok  = (cursor_reg < count_reg);
        stat.out_free   = !out_valid_reg || rsp_ch.ready;
    end

    always_comb
    begin
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        rdv_next       = rdv_reg;

        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end
        if (cmd.load)
        begin
            idx_next    = '0;
            hit_next    = 1'b0;
            status_next = ST_OK;
            rdv_next    = '0;
        end
        if (cmd.idx_inc || cmd.shift_wr)
        begin
            idx_next = idx_plus;
        end
        if (cmd.scan_hit)
        begin
            hit_next = 1'b1;
        end
        if (cmd.set_status)
        begin
            status_next = cmd.status_code;
        end
        if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.dec_count)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.rewind)
        begin
            cursor_next = '0;
        end
        if (cmd.read_cap)
        begin
            rdv_next    = ram_rdata;
            cursor_next = cursor_reg + CW'(1);
        end
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_req_type;
            val_reg <= in_value;
        end
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        rdv_reg    <= rdv_next;
        if (cmd.publish)
        begin
            o_status_reg <= status_reg;
            o_found_reg  <= hit_reg;
            o_value_reg  <= rdv_reg;
            o_count_reg  <= count_wide[COUNT_OUT_W-1:0];
            o_more_reg   <= (cursor_reg < count_reg);
        end
    end

    assign rsp_ch.valid        = out_valid_reg;
    assign rsp_ch.status       = o_status_reg;
    assign rsp_ch.found        = o_found_reg;
    assign rsp_ch.read_value   = o_value_reg;
    assign rsp_ch.entry_count  = o_count_reg;
    assign rsp_ch.more_to_read = o_more_reg;

endmodule

`default_nettype wire

// ===== sv/bounded_integer_set_table.sv =====
// Bounded integer set table: a packed table of signed 32-bit values.
// Requests arrive on req_ch (req_type, value) as valid/ready beats; every
// request gives exactly one result beat on rsp_ch (status, found,
// read_value, entry_count, more_to_read). The capacity limit is written
// through cfg_we/cfg_wdata; the user must do so only while the block is
// idle, and the block itself does not enforce this. One request is handled
// at a time. The entries live in a single-port-write, registered-read RAM,
// so a search reads and compares the stored entries one by one and stops
// at the first match, and a remove reads each later entry and writes it one
// slot down. The block is ready to accept the next request in the same
// cycle that the result beat is offered.
// A result waits in the output register while the next request is taken;
// a later result waits in the controller until rsp_ch.ready frees the
// register, and no new request is accepted meanwhile.
// Reset empties the set, rewinds the read cursor and sets the capacity
// limit to 16; the RAM contents are left as they are and never read
// before being written.
`default_nettype none

module bounded_integer_set_table
    import bist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    bist_req_if.sink              req_ch,
    bist_rsp_if.source            rsp_ch,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata
);

    // Commands from the controller and status from the datapath.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    bist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_ch.valid),
        .in_ready (req_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath captures the request beat when the controller loads it.
    bist_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_req_type (req_ch.req_type),
        .in_value    (req_ch.value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .rsp_ch      (rsp_ch)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bounded integer set table.
// A directed table of requests runs first. After it come eight random phases,
// each with its own capacity setting. The bench keeps a shadow copy of the
// set and predicts each result at the edge where the request beat is
// accepted. Every result beat is then compared with the oldest prediction.
module testbench
    import bist_pkg::*;
();

    // Cycles without any beat on either channel before the run is declared hung.
    // It lies far above the slowest request (a remove over a full table) and
    // the long receiver hold-off below.
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 80;
    localparam int POOL_SIZE    = 6;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Request codes the block does not define. They must leave the state alone.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      found;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      more_to_read;
    } set_result_t;

    // One row of the directed table. A row either writes the capacity or sends
    // one request. Where typed is set, the expected result is given in the row.
    typedef struct {
        bit                        set_cap;
        logic [CAP_W-1:0]          cap;
        logic [REQ_W-1:0]          req_type;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        set_result_t               want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    bist_req_if req_ch ();
    bist_rsp_if rsp_ch ();

    bounded_integer_set_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the set, which the bench updates in request order.
    logic signed [VALUE_W-1:0] shadow_tbl [DEPTH_DEFAULT];
    int shadow_count;
    int shadow_cursor;
    int shadow_cap;

    set_result_t expected_results [$];
    stim_row_t   directed_rows [$];

    logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];
    int phase_caps [PHASE_COUNT] = '{16, 1, 7, 31, 0, 16, 3, 20};

    int  req_idle_pct;
    int  rsp_idle_pct;
    int  walk_left;
    bit  pressure_go;
    logic rsp_hold;

    int items_sent;
    int results_seen;
    int cap_writes;
    int mismatch_count;
    int hit_count;
    int status_tally [4];
    int stuck_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Compute the result of one request and apply the request to the shadow set.
    // The search returns the lowest matching slot. A remove closes the gap it
    // leaves, and the read cursor is not adjusted when it does.
    function automatic set_result_t predict_set_result(input logic [REQ_W-1:0] rq,
                                                       input logic signed [VALUE_W-1:0] v);
        set_result_t r;
        int limit;
        int pos;
        bit hit;
        r = '0;
        // A capacity above the table depth is treated as the table depth.
        limit = (shadow_cap > DEPTH_DEFAULT) ? DEPTH_DEFAULT : shadow_cap;
        hit = 1'b0;
        pos = 0;
        for (int i = shadow_count - 1; i >= 0; i--)
        begin
            if (shadow_tbl[i] == v)
            begin
                hit = 1'b1;
                pos = i;
            end
        end
        case (rq)
            REQ_QUERY:
            begin
                r.found = hit;
            end
            REQ_INSERT:
            begin
                // A value that is already present is still stored, and found is set.
                r.found = hit;
                if (shadow_count < limit)
                begin
                    shadow_tbl[shadow_count] = v;
                    shadow_count++;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            REQ_REMOVE:
            begin
                if (hit)
                begin
                    r.found = 1'b1;
                    for (int j = pos; j < shadow_count - 1; j++)
                        shadow_tbl[j] = shadow_tbl[j + 1];
                    shadow_count--;
                end
                else
                begin
                    r.status = ST_ABSENT;
                end
            end
            REQ_REWIND:
            begin
                shadow_cursor = 0;
            end
            REQ_READ_NEXT:
            begin
                if (shadow_cursor < shadow_count)
                begin
                    r.read_value = shadow_tbl[shadow_cursor];
                    shadow_cursor++;
                end
                else
                begin
                    r.status = ST_READ_PAST_END;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count  = COUNT_OUT_W'(shadow_count);
        r.more_to_read = (shadow_cursor < shadow_count);
        return r;
    endfunction

    function automatic stim_row_t request_row(input logic [REQ_W-1:0] rq,
                                              input logic signed [VALUE_W-1:0] v);
        stim_row_t row;
        row = '{default: '0};
        row.req_type = rq;
        row.value    = v;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic [REQ_W-1:0] rq,
                                            input logic signed [VALUE_W-1:0] v,
                                            input logic [STATUS_W-1:0] st,
                                            input logic fd,
                                            input logic signed [VALUE_W-1:0] rd,
                                            input logic [COUNT_OUT_W-1:0] cnt,
                                            input logic more);
        stim_row_t row;
        row = request_row(rq, v);
        row.typed = 1'b1;
        row.want  = '{st, fd, rd, cnt, more};
        return row;
    endfunction

    function automatic stim_row_t capacity_row(input logic [CAP_W-1:0] c);
        stim_row_t row;
        row = '{default: '0};
        row.set_cap = 1'b1;
        row.cap     = c;
        return row;
    endfunction

    // Offer one request beat and hold it until the block accepts it. If the
    // next request is offered in the same time step, valid stays high and is
    // not lowered in between. The sender may also idle first, with valid low.
    task automatic offer_request(input logic [REQ_W-1:0] rq,
                                 input logic signed [VALUE_W-1:0] v,
                                 input bit typed,
                                 input set_result_t want);
        set_result_t predicted;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rq;
        req_ch.value    <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_set_result(rq, v);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // The capacity may change only while the block is idle. Since every request
    // returns one result, an empty prediction queue means the block is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_cap = c;
        cap_writes++;
    endtask

    // Pick one random request. Values mostly come from a small pool so that
    // queries, removes and duplicate inserts find matches. A rewind is often
    // followed by a run of read-next requests that walks past the last entry.
    task automatic pick_request(output logic [REQ_W-1:0] rq,
                                output logic signed [VALUE_W-1:0] v);
        int roll;
        roll = $urandom_range(99);
        if ($urandom_range(4) == 0)
            v = $urandom;
        else
            v = value_pool[$urandom_range(POOL_SIZE - 1)];
        if (walk_left > 0)
        begin
            rq = REQ_READ_NEXT;
            walk_left--;
        end
        else if (roll < 34)
            rq = REQ_INSERT;
        else if (roll < 54)
            rq = REQ_REMOVE;
        else if (roll < 70)
            rq = REQ_QUERY;
        else if (roll < 86)
            rq = REQ_READ_NEXT;
        else if (roll < 94)
        begin
            rq = REQ_REWIND;
            walk_left = $urandom_range(DEPTH_DEFAULT + 2);
        end
        else
            rq = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    endtask

    function automatic void report_mismatch(input string what, input set_result_t want,
                                            input set_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected st=%0d fd=%0d rd=%0d cnt=%0d more=%0d, ",
                     $realtime, what, want.status, want.found, want.read_value,
                     want.entry_count, want.more_to_read,
                     "got st=%0d fd=%0d rd=%0d cnt=%0d more=%0d",
                     got.status, got.found, got.read_value, got.entry_count,
                     got.more_to_read);
    endfunction

    // Result side. Each result beat is compared with the oldest prediction.
    // After that the receiver chooses its ready for the next cycle. During the
    // long hold-off ready stays low, so the block fills up and stops taking requests.
    always @(posedge clk)
    begin
        set_result_t got;
        set_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.status, rsp_ch.found, rsp_ch.read_value,
                    rsp_ch.entry_count, rsp_ch.more_to_read};
            results_seen++;
            if (!$isunknown(got.status))
                status_tally[got.status]++;
            if (got.found === 1'b1)
                hit_count++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", '0, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.found !== want.found
                    || got.read_value !== want.read_value
                    || got.entry_count !== want.entry_count
                    || got.more_to_read !== want.more_to_read)
                    report_mismatch("result mismatch", want, got);
            end
        end
        rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
    end

    // The long receiver hold-off. This process counts its own cycles.
    initial
    begin
        rsp_hold = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Watchdog. It ends the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [REQ_W-1:0]          rq;
        logic signed [VALUE_W-1:0] v;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.value    = '0;
        pressure_go     = 1'b0;
        walk_left       = 0;
        shadow_count    = 0;
        shadow_cursor   = 0;
        shadow_cap      = CAP_RESET;
        foreach (status_tally[i])
            status_tally[i] = 0;

        // Directed part. The first rows run on the reset capacity of 16 and cover
        // the empty set, the extreme values and a duplicate insert. Later rows
        // read past the end, remove the first match and the last entry, and send
        // the undefined request codes. The capacity is then lowered below the
        // count, set to zero, and set above the table depth.
        directed_rows.push_back(known_row(REQ_READ_NEXT, 0, ST_READ_PAST_END, 0, 0, 0, 0));
        directed_rows.push_back(known_row(REQ_QUERY, VAL_MIN, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(known_row(REQ_REMOVE, VAL_MAX, ST_ABSENT, 0, 0, 0, 0));
        directed_rows.push_back(known_row(REQ_REWIND, 0, ST_OK, 0, 0, 0, 0));
        directed_rows.push_back(known_row(REQ_INSERT, VAL_MIN, ST_OK, 0, 0, 1, 1));
        directed_rows.push_back(known_row(REQ_INSERT, VAL_MAX, ST_OK, 0, 0, 2, 1));
        directed_rows.push_back(known_row(REQ_INSERT, VAL_MIN, ST_OK, 1, 0, 3, 1));
        directed_rows.push_back(request_row(REQ_INSERT, -1));
        directed_rows.push_back(request_row(REQ_INSERT, 0));
        directed_rows.push_back(request_row(REQ_QUERY, VAL_MAX));
        directed_rows.push_back(request_row(REQ_READ_NEXT, 0));
        directed_rows.push_back(request_row(REQ_READ_NEXT, 0));
        directed_rows.push_back(request_row(REQ_REMOVE, VAL_MIN));
        directed_rows.push_back(request_row(REQ_READ_NEXT, 0));
        directed_rows.push_back(request_row(REQ_REMOVE, 0));
        directed_rows.push_back(known_row(REQ_READ_NEXT, -1, ST_READ_PAST_END, 0, 0, 3, 0));
        directed_rows.push_back(request_row(REQ_REWIND, 0));
        directed_rows.push_back(request_row(REQ_UNUSED_LO, 32'sh5A5A_5A5A));
        directed_rows.push_back(request_row(REQ_UNUSED_HI, -1));
        directed_rows.push_back(capacity_row(5'd2));
        directed_rows.push_back(known_row(REQ_INSERT, 42, ST_FULL, 0, 0, 3, 1));
        directed_rows.push_back(request_row(REQ_REMOVE, VAL_MAX));
        directed_rows.push_back(known_row(REQ_INSERT, 42, ST_FULL, 0, 0, 2, 1));
        directed_rows.push_back(capacity_row(5'd0));
        directed_rows.push_back(request_row(REQ_REMOVE, -1));
        directed_rows.push_back(known_row(REQ_INSERT, VAL_MIN, ST_FULL, 1, 0, 1, 1));
        directed_rows.push_back(capacity_row(5'd31));
        directed_rows.push_back(request_row(REQ_INSERT, 7));

        // First idle mode: the sender idles now and then, the receiver often.
        req_idle_pct = 23;
        rsp_idle_pct = 55;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_cap)
                write_capacity(directed_rows[i].cap);
            else
                offer_request(directed_rows[i].req_type, directed_rows[i].value,
                              directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases. The idle modes swap after phase three. The last two
        // phases run with no idling, and the long hold-off falls in phase seven.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_capacity(CAP_W'(phase_caps[p]));
            if (p == 3)
            begin
                req_idle_pct = 55;
                rsp_idle_pct = 23;
            end
            else if (p == 6)
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
                pressure_go  = 1'b1;
            end
            foreach (value_pool[i])
            begin
                case ($urandom_range(5))
                    0: value_pool[i] = VAL_MIN;
                    1: value_pool[i] = VAL_MAX;
                    2: value_pool[i] = 0;
                    3: value_pool[i] = -1;
                    default: value_pool[i] = $urandom;
                endcase
            end
            walk_left = 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick_request(rq, v);
                offer_request(rq, v, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d directed rows) across %0d capacity writes; ",
                 items_sent, directed_rows.size(), cap_writes,
                 "%0d results, %0d hits.", results_seen, hit_count);
        $display("Status mix: %0d ok, %0d full, %0d absent, %0d read past end; ",
                 status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_ABSENT],
                 status_tally[ST_READ_PAST_END], "%0d mismatches.", mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== bounded_integer_set_table.f =====
sv/bist_pkg.sv
sv/bist_req_if.sv
sv/bist_rsp_if.sv
sv/bist_ram.sv
sv/bist_ctrl.sv
sv/bist_dp.sv
sv/bounded_integer_set_table.sv
tb/sv/testbench.sv
